### hw/rtl/lgrs_pkg.sv
// Package with the payload types, the column type and the row constants of the row stream.
package lgrs_pkg;

    localparam int DATA_W    = 64;
    localparam int ROW_WIDTH = 64;
    localparam int COUNT_W   = 4;
    localparam logic [COUNT_W-1:0] NB_TWO   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] NB_THREE = COUNT_W'(3);

    typedef struct packed {
        logic [DATA_W-1:0] row_cells;
        logic              last_row;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] next_row_cells;
        logic              frame_end;
    } t_out_item;

    typedef struct packed {
        logic upper;
        logic center;
        logic row;
    } t_col;

    typedef struct packed {
        logic [1:0] num;
        t_out_item  first;
        t_out_item  second;
    } t_push;

endpackage

### hw/rtl/lgrs_cell.sv
// One column cell: holds the upper and centre bits of its column and applies rule B3/S23.
module lgrs_cell
    import lgrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_clear,
    input  logic i_row_bit,
    input  t_col i_left,
    input  t_col i_right,
    output t_col o_col,
    output logic o_next_mid,
    output logic o_next_last
);

    logic r_upper;
    logic r_center;
    logic n_upper;
    logic n_center;
    logic [COUNT_W-1:0] w_cnt_mid;
    logic [COUNT_W-1:0] w_cnt_last;

    always_comb begin
        n_upper  = r_upper;
        n_center = r_center;
        if (i_clear) begin
            n_upper  = 1'b0;
            n_center = 1'b0;
        end else if (i_shift) begin
            n_upper  = r_center;
            n_center = i_row_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper  <= 1'b0;
            r_center <= 1'b0;
        end else begin
            r_upper  <= n_upper;
            r_center <= n_center;
        end
    end

    always_comb begin
        w_cnt_mid = COUNT_W'(i_left.upper) + COUNT_W'(r_upper) + COUNT_W'(i_right.upper)
                  + COUNT_W'(i_left.center) + COUNT_W'(i_right.center)
                  + COUNT_W'(i_left.row) + COUNT_W'(i_row_bit) + COUNT_W'(i_right.row);
        w_cnt_last = COUNT_W'(i_left.center) + COUNT_W'(r_center) + COUNT_W'(i_right.center)
                   + COUNT_W'(i_left.row) + COUNT_W'(i_right.row);
        o_next_mid  = (w_cnt_mid == NB_THREE) || (r_center && (w_cnt_mid == NB_TWO));
        o_next_last = (w_cnt_last == NB_THREE) || (i_row_bit && (w_cnt_last == NB_TWO));
    end

    assign o_col = '{upper: r_upper, center: r_center, row: i_row_bit};

endmodule

### hw/rtl/lgrs_out_queue.sv
// Two-entry result queue that decouples the cell row from the output channel.
module lgrs_out_queue
    import lgrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_empty_after_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_out_item  r_mem [2];
    logic       r_head;
    logic [1:0] r_count;
    logic       n_head;
    logic [1:0] n_count;
    logic       w_pop;
    logic [1:0] w_cnt_ap;
    logic       w_base;

    always_comb begin
        w_pop    = (r_count != 2'd0) && !i_stall;
        w_cnt_ap = r_count - {1'b0, w_pop};
        w_base   = r_head ^ w_pop;
        n_head   = w_base;
        n_count  = w_cnt_ap + i_push.num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[w_base] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[~w_base] <= i_push.second;
        end
    end

    assign o_empty_after_pop = (w_cnt_ap == 2'd0);
    assign o_valid           = (r_count != 2'd0);
    assign o_data            = r_mem[r_head];

endmodule

### hw/rtl/life_generation_row_stream.sv
// Top level of the row-streaming Game of Life generation step, rule B3/S23.
// A frame enters as one row transaction per cycle while not stalled, one bit per column with 1
// meaning live; a row of one cell per column keeps the two previous rows and, when a row's lower
// neighbour is accepted, queues that row's next generation for the output in the following
// cycle. A row marked last gives two result transactions, or one when it is the only row of its
// frame, the final one carrying frame_end, and the block then starts a fresh frame. Results pass
// through a two-entry queue, so a row is accepted in every cycle while the output side takes a
// result each cycle; a row is only accepted once the queue will be empty after the current output
// transaction, so the second result of a last row holds back the next row.
module life_generation_row_stream
    import lgrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic                 r_center_valid;
    logic                 n_center_valid;
    logic                 w_accept;
    logic                 w_space;
    logic                 w_shift;
    logic                 w_clear;
    t_col                 w_col   [ROW_WIDTH];
    t_col                 w_left  [ROW_WIDTH];
    t_col                 w_right [ROW_WIDTH];
    logic [DATA_W-1:0]    w_next_mid;
    logic [DATA_W-1:0]    w_next_last;
    logic [ROW_WIDTH-1:0] w_state_bits;
    t_push                w_push;

    assign o_stall  = !w_space;
    assign w_accept = i_valid && w_space;
    assign w_shift  = w_accept && !i_data.last_row;
    assign w_clear  = w_accept && i_data.last_row;

    genvar c;
    generate
        for (c = 0; c < DATA_W; c++) begin : g_col
            if (c < ROW_WIDTH) begin : g_cell
                if (c == 0) begin : g_left_edge
                    assign w_left[c] = '0;
                end else begin : g_left_nb
                    assign w_left[c] = w_col[c-1];
                end
                if (c == ROW_WIDTH - 1) begin : g_right_edge
                    assign w_right[c] = '0;
                end else begin : g_right_nb
                    assign w_right[c] = w_col[c+1];
                end
                lgrs_cell u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_shift     (w_shift),
                    .i_clear     (w_clear),
                    .i_row_bit   (i_data.row_cells[c]),
                    .i_left      (w_left[c]),
                    .i_right     (w_right[c]),
                    .o_col       (w_col[c]),
                    .o_next_mid  (w_next_mid[c]),
                    .o_next_last (w_next_last[c])
                );
                assign w_state_bits[c] = w_col[c].upper | w_col[c].center;
            end else begin : g_unused
                assign w_next_mid[c]  = 1'b0;
                assign w_next_last[c] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        n_center_valid = r_center_valid;
        if (w_clear) begin
            n_center_valid = 1'b0;
        end else if (w_shift) begin
            n_center_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_valid <= 1'b0;
        end else begin
            r_center_valid <= n_center_valid;
        end
    end

    always_comb begin
        w_push.num    = 2'd0;
        w_push.first  = '{next_row_cells: w_next_last, frame_end: 1'b1};
        w_push.second = '{next_row_cells: w_next_last, frame_end: 1'b1};
        if (w_accept) begin
            w_push.num = {1'b0, r_center_valid} + {1'b0, i_data.last_row};
            if (r_center_valid) begin
                w_push.first = '{next_row_cells: w_next_mid, frame_end: 1'b0};
            end
        end
    end

    lgrs_out_queue u_queue (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (w_push),
        .o_empty_after_pop (w_space),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data            (o_data)
    );

    a_idle_rows_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_center_valid |-> (w_state_bits == '0))
        else $error("Held rows are not dead while no centre row is held.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_center_valid || i_data.last_row)) |=> o_valid)
        else $error("An accepted row that yields a result left the output empty.");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> !r_center_valid)
        else $error("A last row did not restart the frame.");

endmodule
